// File: src/tmpg_pkg.sv
package tmpg_pkg;

    localparam int DEF_CELL_COLUMNS  = 32;
    localparam int DEF_CELL_ROWS     = 12;
    localparam int DEF_BORDER_PIXELS = 16;
    localparam int DEF_GLYPH_COUNT   = 128;

    localparam int PAL_DEPTH = 16;
    localparam int PAL_WIDTH = 12;
    localparam int WORD_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam logic [7:0]  LVL_HI       = 8'd170;
    localparam logic [7:0]  LVL_LO       = 8'd85;
    localparam logic [7:0]  NIBBLE_SCALE = 8'd17;
    localparam logic [23:0] BOOT_RGB     = 24'h0000AA;
    localparam logic [3:0]  BROWN_IDX    = 4'd6;

    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_GLYPH = 2'd1,
        CMD_PAL   = 2'd2,
        CMD_PIXEL = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_ENABLE = 2'd0,
        CFG_CUSTOM_PALETTE = 2'd1,
        CFG_BORDER_COLOR   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_GLYPH
    } t_state;

    typedef struct packed {
        logic       border;
        logic [1:0] cx;
        logic [2:0] cy;
    } t_locate;

    typedef struct packed {
        logic       enable;
        logic       custom;
        logic       border;
        logic       hide;
        logic       glyph_ok;
        logic       cx_lsb;
        logic [2:0] cy;
        logic [3:0] fg_idx;
        logic [3:0] bg_idx;
    } t_shade_ctl;

    function automatic logic [23:0] builtin_colour(input logic [3:0] idx);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        b = idx[0] ? LVL_HI : 8'd0;
        g = idx[1] ? LVL_HI : 8'd0;
        r = idx[2] ? LVL_HI : 8'd0;
        if (idx == BROWN_IDX) begin
            g = LVL_LO;
        end else if (idx[3]) begin
            r = r + LVL_LO;
            g = g + LVL_LO;
            b = b + LVL_LO;
        end
        return {r, g, b};
    endfunction

    function automatic logic [23:0] custom_colour(input logic [PAL_WIDTH-1:0] w);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = 8'({4'd0, w[11:8]} * NIBBLE_SCALE);
        g = 8'({4'd0, w[7:4]} * NIBBLE_SCALE);
        b = 8'({4'd0, w[3:0]} * NIBBLE_SCALE);
        return {r, g, b};
    endfunction

endpackage

// File: src/text_mode_pixel_generator.sv
// Text-mode pixel generator: screen map, glyph and palette stores, RGB per pixel.
// Input channel (i_in_valid / o_in_ready): one transaction per command. Map,
// glyph and palette writes complete in the accepting cycle; an index beyond
// the store is dropped. A pixel request (cmd 3) produces one output
// transaction on o_out_valid / i_out_ready.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready; index 0
// display enable, 1 custom palette select, 2 border colour.
// A pixel request, once accepted, steps through ST_MAP and ST_GLYPH for the
// two dependent synchronous reads: map word, then glyph and palette words.
// o_in_ready is high only in ST_IDLE, so other commands wait until it returns.
// The output register decouples the receiver: the next command is accepted
// while a result waits. If a second result is ready while the first still
// waits, the block holds in its final step until the output is taken.
// Reset clears the configuration, the sequencer and the output valid; store
// contents are undefined until written.
module text_mode_pixel_generator
    import tmpg_pkg::*;
#(
    parameter int CELL_COLUMNS  = DEF_CELL_COLUMNS,
    parameter int CELL_ROWS     = DEF_CELL_ROWS,
    parameter int BORDER_PIXELS = DEF_BORDER_PIXELS,
    parameter int GLYPH_COUNT   = DEF_GLYPH_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_cmd,
    input  logic [8:0]           i_index,
    input  logic [15:0]          i_data,
    input  logic [7:0]           i_pixel_x,
    input  logic [6:0]           i_pixel_y,
    input  logic                 i_blink_phase,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic                 o_in_border
);

    localparam int MAP_DEPTH   = CELL_COLUMNS * CELL_ROWS;
    localparam int MAP_AW      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int GLYPH_DEPTH = GLYPH_COUNT * 2;
    localparam int GLY_AW      = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
    localparam int PAL_AW      = $clog2(PAL_DEPTH);

    t_state r_state, n_state;

    logic       r_display_enable;
    logic       r_use_custom;
    logic [3:0] r_border_color;

    logic       r_border;
    logic [1:0] r_cx;
    logic [2:0] r_cy;
    logic       r_blink;
    logic [3:0] r_fg_idx;
    logic [3:0] r_bg_idx;
    logic       r_hide;
    logic       r_glyph_ok;

    logic       r_out_valid;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;
    logic       r_out_border;

    logic        in_acc;
    logic        map_re;
    logic        glyph_re;
    logic        load_out;
    logic [15:0] idx_w;
    logic        map_we;
    logic        glyph_we;
    logic        pal_we;

    t_locate           loc;
    logic [MAP_AW-1:0] cell_addr;

    logic [WORD_W-1:0]    map_word;
    logic [WORD_W-1:0]    glyph_word;
    logic [PAL_WIDTH-1:0] pal_fg;
    logic [PAL_WIDTH-1:0] pal_bg;
    logic [3:0]           fg_sel;
    logic [7:0]           glyph_full;
    logic [GLY_AW-1:0]    glyph_addr;
    t_shade_ctl           shade_ctl;
    logic [23:0]          rgb;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign idx_w       = 16'(i_index);

    assign map_we   = in_acc && (i_cmd == CMD_MAP)   && (idx_w < 16'(MAP_DEPTH));
    assign glyph_we = in_acc && (i_cmd == CMD_GLYPH) && (idx_w < 16'(GLYPH_DEPTH));
    assign pal_we   = in_acc && (i_cmd == CMD_PAL)   && (idx_w < 16'(PAL_DEPTH));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_cmd == CMD_PIXEL) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                n_state = ST_GLYPH;
            end
            ST_GLYPH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        map_re     = 1'b0;
        glyph_re   = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                map_re     = i_in_valid && (i_cmd == CMD_PIXEL) && !loc.border;
            end
            ST_MAP: begin
                glyph_re = 1'b1;
            end
            ST_GLYPH: begin
                load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    tmpg_locate #(
        .CELL_COLUMNS  (CELL_COLUMNS),
        .CELL_ROWS     (CELL_ROWS),
        .BORDER_PIXELS (BORDER_PIXELS)
    ) u_locate (
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .o_loc     (loc),
        .o_cell    (cell_addr)
    );

    tmpg_ram #(.WIDTH(WORD_W), .DEPTH(MAP_DEPTH)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (idx_w[MAP_AW-1:0]),
        .i_wdata (i_data),
        .i_re    (map_re),
        .i_raddr (cell_addr),
        .o_rdata (map_word)
    );

    assign fg_sel     = r_border ? r_border_color : map_word[15:12];
    assign glyph_full = {map_word[6:0], r_cx[1]};
    assign glyph_addr = glyph_full[GLY_AW-1:0];

    tmpg_ram #(.WIDTH(WORD_W), .DEPTH(GLYPH_DEPTH)) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (glyph_we),
        .i_waddr (idx_w[GLY_AW-1:0]),
        .i_wdata (i_data),
        .i_re    (glyph_re),
        .i_raddr (glyph_addr),
        .o_rdata (glyph_word)
    );

    tmpg_ram #(.WIDTH(PAL_WIDTH), .DEPTH(PAL_DEPTH)) u_pal_fg_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (idx_w[PAL_AW-1:0]),
        .i_wdata (i_data[PAL_WIDTH-1:0]),
        .i_re    (glyph_re),
        .i_raddr (fg_sel),
        .o_rdata (pal_fg)
    );

    tmpg_ram #(.WIDTH(PAL_WIDTH), .DEPTH(PAL_DEPTH)) u_pal_bg_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (idx_w[PAL_AW-1:0]),
        .i_wdata (i_data[PAL_WIDTH-1:0]),
        .i_re    (glyph_re),
        .i_raddr (map_word[11:8]),
        .o_rdata (pal_bg)
    );

    always_comb begin
        shade_ctl.enable   = r_display_enable;
        shade_ctl.custom   = r_use_custom;
        shade_ctl.border   = r_border;
        shade_ctl.hide     = r_hide;
        shade_ctl.glyph_ok = r_glyph_ok;
        shade_ctl.cx_lsb   = r_cx[0];
        shade_ctl.cy       = r_cy;
        shade_ctl.fg_idx   = r_fg_idx;
        shade_ctl.bg_idx   = r_bg_idx;
    end

    tmpg_shade u_shade (
        .i_ctl        (shade_ctl),
        .i_glyph_word (glyph_word),
        .i_pal_fg     (pal_fg),
        .i_pal_bg     (pal_bg),
        .o_rgb        (rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_display_enable <= 1'b0;
            r_use_custom     <= 1'b0;
            r_border_color   <= 4'd0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DISPLAY_ENABLE: r_display_enable <= i_cfg_data[0];
                    CFG_CUSTOM_PALETTE: r_use_custom     <= i_cfg_data[0];
                    CFG_BORDER_COLOR:   r_border_color   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_cmd == CMD_PIXEL) begin
            r_border <= loc.border;
            r_cx     <= loc.cx;
            r_cy     <= loc.cy;
            r_blink  <= i_blink_phase;
        end
        if (glyph_re) begin
            r_fg_idx   <= fg_sel;
            r_bg_idx   <= map_word[11:8];
            r_hide     <= map_word[7] & r_blink;
            r_glyph_ok <= {1'b0, map_word[6:0]} < 8'(GLYPH_COUNT);
        end
        if (load_out) begin
            r_red        <= rgb[23:16];
            r_green      <= rgb[15:8];
            r_blue       <= rgb[7:0];
            r_out_border <= r_border;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_in_border = r_out_border;

endmodule

// File: src/tmpg_ram.sv
module tmpg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/tmpg_locate.sv
module tmpg_locate
    import tmpg_pkg::*;
#(
    parameter int CELL_COLUMNS  = DEF_CELL_COLUMNS,
    parameter int CELL_ROWS     = DEF_CELL_ROWS,
    parameter int BORDER_PIXELS = DEF_BORDER_PIXELS,
    localparam int MAP_DEPTH = CELL_COLUMNS * CELL_ROWS,
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1
) (
    input  logic [7:0]        i_pixel_x,
    input  logic [6:0]        i_pixel_y,
    output t_locate           o_loc,
    output logic [MAP_AW-1:0] o_cell
);

    localparam int X_LO = BORDER_PIXELS;
    localparam int X_HI = BORDER_PIXELS + CELL_COLUMNS * 4;
    localparam int Y_LO = BORDER_PIXELS;
    localparam int Y_HI = BORDER_PIXELS + CELL_ROWS * 8;

    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] cell_addr;

    always_comb begin
        px = 16'(i_pixel_x);
        py = 16'(i_pixel_y);
        ax = px - 16'(X_LO);
        ay = py - 16'(Y_LO);
        cell_addr = 16'((ay >> 3) * 16'(CELL_COLUMNS)) + (ax >> 2);
        o_loc.border = !(px >= 16'(X_LO) && px < 16'(X_HI) &&
                         py >= 16'(Y_LO) && py < 16'(Y_HI));
        o_loc.cx = ax[1:0];
        o_loc.cy = ay[2:0];
        o_cell = cell_addr[MAP_AW-1:0];
    end

endmodule

// File: src/tmpg_shade.sv
module tmpg_shade
    import tmpg_pkg::*;
(
    input  t_shade_ctl            i_ctl,
    input  logic [WORD_W-1:0]     i_glyph_word,
    input  logic [PAL_WIDTH-1:0]  i_pal_fg,
    input  logic [PAL_WIDTH-1:0]  i_pal_bg,
    output logic [23:0]           o_rgb
);

    logic [23:0] fg;
    logic [23:0] bg;
    logic        pix_bit;

    always_comb begin
        fg = i_ctl.custom ? custom_colour(i_pal_fg) : builtin_colour(i_ctl.fg_idx);
        bg = i_ctl.custom ? custom_colour(i_pal_bg) : builtin_colour(i_ctl.bg_idx);
        pix_bit = i_ctl.glyph_ok & i_glyph_word[{~i_ctl.cx_lsb, i_ctl.cy}];
        if (!i_ctl.enable) begin
            o_rgb = BOOT_RGB;
        end else if (i_ctl.border) begin
            o_rgb = fg;
        end else if (pix_bit && !i_ctl.hide) begin
            o_rgb = fg;
        end else begin
            o_rgb = bg;
        end
    end

endmodule

// File: src/tmpg_checker.sv
module tmpg_props
    import tmpg_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_cmd,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic       o_in_border
);

    logic pix_acc;
    assign pix_acc = i_in_valid && o_in_ready && (i_cmd == CMD_PIXEL);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_red) && $stable(o_green) &&
            $stable(o_blue) && $stable(o_in_border))
        else $error("output transaction changed while stalled");

    a_pix_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc |=> !o_in_ready)
        else $error("input accepted while pixel lookup in progress");

    a_pix_busy2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc |=> ##1 !o_in_ready)
        else $error("input accepted before pixel result produced");

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(pix_acc, 3))
        else $error("output transaction without matching pixel request");

endmodule

bind text_mode_pixel_generator tmpg_props u_tmpg_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_cmd       (i_cmd),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_red       (o_red),
    .o_green     (o_green),
    .o_blue      (o_blue),
    .o_in_border (o_in_border)
);
